/* sv/psd_pkg.sv */
// ---------------------------------------------------------------------------
// psd_pkg
// Shared types and constants for the point to segment distance pipeline.
// ---------------------------------------------------------------------------
package psd_pkg;

  // Coordinate and fraction formats.
  localparam int CoordBits = 16;
  localparam int FracBits  = 16;
  localparam int DiffBits  = CoordBits + 1;          // exact coordinate differences
  localparam int ProdBits  = 2 * DiffBits;           // one product of two differences
  localparam int SumBits   = ProdBits + 2;           // sum of three products
  localparam int TBits     = FracBits + 1;           // clamped t, one included
  localparam int ScaleBits = DiffBits + FracBits + 2; // difference times t
  localparam int DistBits  = 34;

  // How t is chosen for a request.
  typedef enum logic [1:0] {
    T_ZERO = 2'd0,
    T_ONE  = 2'd1,
    T_DIV  = 2'd2
  } tsel_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic signed [CoordBits-1:0] point_z;
    logic signed [CoordBits-1:0] start_x;
    logic signed [CoordBits-1:0] start_y;
    logic signed [CoordBits-1:0] start_z;
    logic signed [CoordBits-1:0] end_x;
    logic signed [CoordBits-1:0] end_y;
    logic signed [CoordBits-1:0] end_z;
  } req_t;

  typedef struct packed {
    logic [DistBits-1:0]         distance_squared;
    logic [TBits-1:0]            segment_fraction;
    logic signed [CoordBits-1:0] nearest_x;
    logic signed [CoordBits-1:0] nearest_y;
    logic signed [CoordBits-1:0] nearest_z;
    logic                        degenerate;
  } rsp_t;

  // Data that rides alongside the divider.
  typedef struct packed {
    logic [2:0][CoordBits-1:0] p;
    logic [2:0][CoordBits-1:0] a;
    logic [2:0][DiffBits-1:0]  d;
    logic                      degen;
    tsel_t                     sel;
  } side_t;

endpackage

/* sv/psd_div.sv */
// ---------------------------------------------------------------------------
// psd_div
// Pipelined restoring divider: one quotient bit per stage, FracBits stages.
// Computes floor((num << FracBits) / den) for num < den.
// ---------------------------------------------------------------------------
module psd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [psd_pkg::SumBits-1:0]  num,
  input  logic [psd_pkg::SumBits-1:0]  den,
  output logic                         out_valid,
  output logic [psd_pkg::FracBits-1:0] quot
);
  import psd_pkg::*;

  logic [SumBits-1:0]  rem_r [FracBits];
  logic [SumBits-1:0]  den_r [FracBits];
  logic [FracBits-1:0] q_r   [FracBits];
  logic [FracBits-1:0] vld_r;

  logic [SumBits-1:0]  rem_nxt [FracBits];
  logic [FracBits-1:0] q_nxt   [FracBits];

  // One shift, compare and subtract per stage.
  always_comb begin
    logic [SumBits:0]    sh;
    logic [SumBits-1:0]  r_in;
    logic [SumBits-1:0]  d_in;
    logic [FracBits-1:0] q_in;
    for (int k = 0; k < FracBits; k++) begin
      r_in = (k == 0) ? num : rem_r[(k == 0) ? 0 : k-1];
      d_in = (k == 0) ? den : den_r[(k == 0) ? 0 : k-1];
      q_in = (k == 0) ? '0  : q_r[(k == 0) ? 0 : k-1];
      sh   = {r_in, 1'b0};
      if (sh >= {1'b0, d_in}) begin
        rem_nxt[k] = SumBits'(sh - {1'b0, d_in});
        q_nxt[k]   = {q_in[FracBits-2:0], 1'b1};
      end else begin
        rem_nxt[k] = sh[SumBits-1:0];
        q_nxt[k]   = {q_in[FracBits-2:0], 1'b0};
      end
    end
  end

  // Stage registers advance together under the shared enable.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < FracBits; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
        den_r[k] <= (k == 0) ? den : den_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[FracBits-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[FracBits-1];
  assign quot      = q_r[FracBits-1];

endmodule

/* sv/point_segment_distance_squared_core.sv */
// ---------------------------------------------------------------------------
// point_segment_distance_squared_core
// Squared distance from a point to a 3D segment, with clamped t and nearest
// point, in a fully pipelined datapath.
// ---------------------------------------------------------------------------
// Usage:
//   A request on in_data (point, segment start, segment end, Q8.8) is taken
//   when in_valid and in_ready are high. The response on out_data carries
//   the squared distance (Q18.16), t (Q1.16), the nearest point and a flag
//   for a zero-length segment; it is taken when out_valid and out_ready
//   are high.
//   Differences, products, sums and classification are registered before
//   the divider, which has one stage per quotient bit; scaling, nearest
//   point, squares and output are registered after it.
//   Throughput is one request per cycle while the output is not stalled;
//   the divider's stages set the depth, not the rate.
//   The whole pipeline moves on one enable. While out_valid is high and
//   out_ready low the pipeline holds and in_ready is low; nothing is lost
//   or repeated.
//   Reset clears all valid bits; no response is shown after reset until a
//   request has gone through.
// ---------------------------------------------------------------------------
module point_segment_distance_squared_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  psd_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output psd_pkg::rsp_t out_data
);
  import psd_pkg::*;

  logic en;
  logic [3:0] vld_r;      // stages one to four
  logic [2:0] vld_b_r;    // stages five to seven

  // Stage one: differences.
  logic [2:0][CoordBits-1:0] p1_r, a1_r;
  logic [2:0][DiffBits-1:0]  d1_r, v1_r;
  // Stage two: products.
  logic [2:0][CoordBits-1:0] p2_r, a2_r;
  logic [2:0][DiffBits-1:0]  d2_r;
  logic [2:0][ProdBits-1:0]  vd2_r, dd2_r;
  // Stage three: sums.
  logic [2:0][CoordBits-1:0] p3_r, a3_r;
  logic [2:0][DiffBits-1:0]  d3_r;
  logic signed [SumBits-1:0] dot3_r, len3_r;
  // Stage four: classification.
  side_t                     side4_r;
  logic [SumBits-1:0]        num4_r, den4_r;
  // Divider side line.
  side_t                     side_r [FracBits];
  logic                      div_vld;
  logic [FracBits-1:0]       quot;
  // Stage five: scaled differences.
  logic [2:0][CoordBits-1:0] p5_r, a5_r;
  logic [2:0][ScaleBits-1:0] prod5_r;
  logic [TBits-1:0]          t5_r;
  logic [TBits-1:0]          t5_nxt;
  logic                      dg5_r;
  // Stage six: nearest point and offset.
  logic [2:0][CoordBits-1:0] n6_r;
  logic [2:0][DiffBits-1:0]  df6_r;
  logic [TBits-1:0]          t6_r;
  logic                      dg6_r;
  // Stage seven: squares.
  logic [2:0][CoordBits-1:0] n7_r;
  logic [2:0][ProdBits-1:0]  sq7_r;
  logic [TBits-1:0]          t7_r;
  logic                      dg7_r;
  // Output register.
  rsp_t                      out_r;
  logic                      out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Pipeline enables and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      vld_b_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[2:0], in_valid};
      vld_b_r     <= {vld_b_r[1:0], div_vld};
      out_valid_r <= vld_b_r[2];
    end
  end

  // Stage one: V = P - A and D = B - A.
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= {in_data.point_z, in_data.point_y, in_data.point_x};
      a1_r <= {in_data.start_z, in_data.start_y, in_data.start_x};
      d1_r[0] <= DiffBits'(in_data.end_x) - DiffBits'(in_data.start_x);
      d1_r[1] <= DiffBits'(in_data.end_y) - DiffBits'(in_data.start_y);
      d1_r[2] <= DiffBits'(in_data.end_z) - DiffBits'(in_data.start_z);
      v1_r[0] <= DiffBits'(in_data.point_x) - DiffBits'(in_data.start_x);
      v1_r[1] <= DiffBits'(in_data.point_y) - DiffBits'(in_data.start_y);
      v1_r[2] <= DiffBits'(in_data.point_z) - DiffBits'(in_data.start_z);
    end
  end

  // Stage two: per-axis products for the dot and the squared length.
  always_ff @(posedge clk) begin
    if (en) begin
      p2_r <= p1_r;
      a2_r <= a1_r;
      d2_r <= d1_r;
      for (int i = 0; i < 3; i++) begin
        vd2_r[i] <= ProdBits'($signed(v1_r[i]) * $signed(d1_r[i]));
        dd2_r[i] <= ProdBits'($signed(d1_r[i]) * $signed(d1_r[i]));
      end
    end
  end

  // Stage three: sums of three products.
  always_ff @(posedge clk) begin
    if (en) begin
      p3_r   <= p2_r;
      a3_r   <= a2_r;
      d3_r   <= d2_r;
      dot3_r <= SumBits'($signed(vd2_r[0])) + SumBits'($signed(vd2_r[1]))
              + SumBits'($signed(vd2_r[2]));
      len3_r <= SumBits'($signed(dd2_r[0])) + SumBits'($signed(dd2_r[1]))
              + SumBits'($signed(dd2_r[2]));
    end
  end

  // Stage four: pick zero, one or a quotient for t.
  always_ff @(posedge clk) begin
    if (en) begin
      side4_r.p     <= p3_r;
      side4_r.a     <= a3_r;
      side4_r.d     <= d3_r;
      side4_r.degen <= (len3_r == '0);
      if (len3_r == '0 || dot3_r <= SumBits'(0)) begin
        side4_r.sel <= T_ZERO;
      end else if (dot3_r >= len3_r) begin
        side4_r.sel <= T_ONE;
      end else begin
        side4_r.sel <= T_DIV;
      end
      num4_r <= dot3_r;
      den4_r <= len3_r;
    end
  end

  psd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld_r[3]),
    .num       (num4_r),
    .den       (den4_r),
    .out_valid (div_vld),
    .quot      (quot)
  );

  // Side data delayed to line up with the quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < FracBits; k++) begin
        side_r[k] <= (k == 0) ? side4_r : side_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Stage five: final t and D * t.
  always_comb begin
    case (side_r[FracBits-1].sel)
      T_ZERO:  t5_nxt = '0;
      T_ONE:   t5_nxt = TBits'(1) << FracBits;
      T_DIV:   t5_nxt = {1'b0, quot};
      default: t5_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p5_r  <= side_r[FracBits-1].p;
      a5_r  <= side_r[FracBits-1].a;
      t5_r  <= t5_nxt;
      dg5_r <= side_r[FracBits-1].degen;
      for (int i = 0; i < 3; i++) begin
        prod5_r[i] <= ScaleBits'($signed(side_r[FracBits-1].d[i]))
                    * ScaleBits'($signed({1'b0, t5_nxt}));
      end
    end
  end

  // Stage six: N = A + floor(D * t), then P - N.
  logic [2:0][CoordBits-1:0] n6_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n6_nxt[i] = CoordBits'(ScaleBits'($signed(a5_r[i]))
                + ($signed(prod5_r[i]) >>> FracBits));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n6_r  <= n6_nxt;
      t6_r  <= t5_r;
      dg6_r <= dg5_r;
      for (int i = 0; i < 3; i++) begin
        df6_r[i] <= DiffBits'($signed(p5_r[i])) - DiffBits'($signed(n6_nxt[i]));
      end
    end
  end

  // Stage seven: squares of the offsets.
  always_ff @(posedge clk) begin
    if (en) begin
      n7_r  <= n6_r;
      t7_r  <= t6_r;
      dg7_r <= dg6_r;
      for (int i = 0; i < 3; i++) begin
        sq7_r[i] <= ProdBits'($signed(df6_r[i]) * $signed(df6_r[i]));
      end
    end
  end

  // Output register: sum of squares.
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.distance_squared <= DistBits'(SumBits'(sq7_r[0]) + SumBits'(sq7_r[1])
                                        + SumBits'(sq7_r[2]));
      out_r.segment_fraction <= t7_r;
      out_r.nearest_x        <= n7_r[0];
      out_r.nearest_y        <= n7_r[1];
      out_r.nearest_z        <= n7_r[2];
      out_r.degenerate       <= dg7_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* sv/psd_checker.sv */
// ---------------------------------------------------------------------------
// psd_checker
// Port-level checks for the point to segment distance core.
// ---------------------------------------------------------------------------
module psd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input psd_pkg::rsp_t out_data
);
  import psd_pkg::*;

  // A stalled response holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("response changed while stalled");

  // No response right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid after reset");

  // A zero-length segment always reports t of zero.
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.segment_fraction == '0)
    else $error("degenerate segment with nonzero t");

  // t never exceeds one.
  a_trange: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.segment_fraction <= (TBits'(1) << FracBits))
    else $error("t out of range");

  // The core stalls its input whenever the output is held.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

bind point_segment_distance_squared_core psd_checker u_psd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/tb_point_segment_distance_squared_core.sv */
// ---------------------------------------------------------------------------
// tb_point_segment_distance_squared_core
// Self-checking bench for the point to segment distance pipeline. Directed
// corner requests, then random geometry under several flow-control phases,
// each response checked field by field against a behavioral predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_point_segment_distance_squared_core;
  import psd_pkg::*;

  // Phase codes for the idling pattern.
  typedef enum int {
    PH_NONE  = 0,
    PH_SEND  = 1,
    PH_RECV  = 2,
    PH_BOTH  = 3
  } phase_t;

  localparam int  NumRandom   = 830;
  localparam int  Latency     = 8 + FracBits;
  localparam int  LongHold    = 200;
  localparam int  ReqBits     = $bits(req_t);
  localparam longint CycleLimit = 400000;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  req_t  in_data;
  logic  out_valid;
  logic  out_ready;
  rsp_t  out_data;

  req_t   pending_reqs[$];
  rsp_t   expected_rsps[$];
  phase_t phase;
  logic   hold_recv;
  int     errors;
  longint cycle_count;

  point_segment_distance_squared_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor of a signed product divided by 2^FracBits.
  function automatic longint floor_frac(input longint prod);
    return prod >>> FracBits;
  endfunction

  // Predicts the response for one request.
  function automatic rsp_t nearest_point_distance(input req_t r);
    rsp_t   rsp;
    longint pt[3], st[3], en[3], dv[3], vv[3], nr[3];
    longint dotp, len_sq, t_frac, diff;
    longint unsigned dist_acc;
    pt = '{r.point_x, r.point_y, r.point_z};
    st = '{r.start_x, r.start_y, r.start_z};
    en = '{r.end_x, r.end_y, r.end_z};
    dotp = 0;
    len_sq = 0;
    dist_acc = 0;
    for (int i = 0; i < 3; i++) begin
      dv[i] = en[i] - st[i];
      vv[i] = pt[i] - st[i];
      dotp += vv[i] * dv[i];
      len_sq += dv[i] * dv[i];
    end
    if (len_sq == 0 || dotp <= 0) begin
      t_frac = 0;
    end else if (dotp >= len_sq) begin
      t_frac = longint'(1) << FracBits;
    end else begin
      t_frac = (dotp << FracBits) / len_sq;
    end
    for (int i = 0; i < 3; i++) begin
      if (t_frac == 0) begin
        nr[i] = st[i];
      end else if (t_frac == (longint'(1) << FracBits)) begin
        nr[i] = en[i];
      end else begin
        nr[i] = st[i] + floor_frac(dv[i] * t_frac);
      end
      diff = pt[i] - nr[i];
      dist_acc += longint'(diff * diff);
    end
    rsp.distance_squared = dist_acc[DistBits-1:0];
    rsp.segment_fraction = t_frac[TBits-1:0];
    rsp.nearest_x        = nr[0][CoordBits-1:0];
    rsp.nearest_y        = nr[1][CoordBits-1:0];
    rsp.nearest_z        = nr[2][CoordBits-1:0];
    rsp.degenerate       = (len_sq == 0);
    return rsp;
  endfunction

  function automatic logic [15:0] rand_coord();
    logic [15:0] c;
    case ($urandom_range(0, 9))
      0: c = 16'h8000;
      1: c = 16'h7fff;
      2: c = 16'($signed($urandom_range(0, 64)) - 32);
      default: c = 16'($urandom);
    endcase
    return c;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r = ReqBits'({$urandom, $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(0, 7))
      0: begin
        r.end_x = r.start_x;
        r.end_y = r.start_y;
        r.end_z = r.start_z;
      end
      1: begin
        // Small segment near the point, to hit the divide path densely.
        r.start_x = r.point_x + 16'($signed($urandom_range(0, 512)) - 256);
        r.start_y = r.point_y + 16'($signed($urandom_range(0, 512)) - 256);
        r.start_z = r.point_z + 16'($signed($urandom_range(0, 512)) - 256);
        r.end_x   = r.point_x + 16'($signed($urandom_range(0, 512)) - 256);
        r.end_y   = r.point_y + 16'($signed($urandom_range(0, 512)) - 256);
        r.end_z   = r.point_z + 16'($signed($urandom_range(0, 512)) - 256);
      end
      2: begin
        r.point_x = rand_coord();
        r.start_x = rand_coord();
        r.end_x   = rand_coord();
        r.point_y = rand_coord();
        r.start_y = rand_coord();
        r.end_y   = rand_coord();
      end
      default: ;
    endcase
    return r;
  endfunction

  // Directed corners and random requests.
  initial begin
    req_t r;
    // Degenerate segment at the origin.
    pending_reqs.push_back('0);
    // Degenerate segment with the point at the far extreme.
    r = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
          16'h8000, 16'h8000, 16'h8000};
    pending_reqs.push_back(r);
    // Longest segment with the point at each end and at its middle.
    r = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
          16'h7fff, 16'h7fff, 16'h7fff};
    pending_reqs.push_back(r);
    r.point_x = 16'h7fff; r.point_y = 16'h7fff; r.point_z = 16'h7fff;
    pending_reqs.push_back(r);
    r.point_x = 16'h0000; r.point_y = 16'h0000; r.point_z = 16'h0000;
    pending_reqs.push_back(r);
    r.point_x = 16'h7fff; r.point_y = 16'h8000; r.point_z = 16'h0100;
    pending_reqs.push_back(r);
    // Point behind the start, dot negative.
    r = '{16'hff00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0100, 16'h0000, 16'h0000};
    pending_reqs.push_back(r);
    // Dot exactly zero, perpendicular.
    r = '{16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0100, 16'h0000, 16'h0000};
    pending_reqs.push_back(r);
    // Dot exactly equal to the length squared.
    r = '{16'h0100, 16'h0300, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0100, 16'h0000, 16'h0000};
    pending_reqs.push_back(r);
    // Fractions with negative direction, to exercise floor rounding.
    r = '{16'h0001, 16'h0005, 16'hfffd, 16'h0003, 16'h0000, 16'h0000,
          16'hfffd, 16'h0007, 16'hfff9};
    pending_reqs.push_back(r);
    r = '{16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h0000,
          16'hfffd, 16'hfffd, 16'hfffd};
    pending_reqs.push_back(r);
    // Tiny segment, shortest nonzero length.
    r = '{16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000,
          16'h0000, 16'h0000, 16'h0001};
    pending_reqs.push_back(r);
    r = '{16'h1234, 16'h8000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000,
          16'h0001, 16'h8000, 16'h7fff};
    pending_reqs.push_back(r);
    for (int i = 0; i < NumRandom; i++) begin
      pending_reqs.push_back(rand_req());
    end
  end

  // Reset, phase sequencing, and end of run.
  initial begin
    rst_n     = 1'b0;
    hold_recv = 1'b0;
    phase     = PH_NONE;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (pending_reqs.size() < 780);
    phase = PH_SEND;
    wait (pending_reqs.size() < 600);
    phase = PH_RECV;
    wait (pending_reqs.size() < 420);
    phase = PH_BOTH;
    wait (pending_reqs.size() < 300);
    // Receiver holds off long enough for the pipeline to fill and stall input.
    phase = PH_NONE;
    @(negedge clk);
    hold_recv = 1'b1;
    repeat (LongHold) @(negedge clk);
    hold_recv = 1'b0;
    wait (pending_reqs.size() < 150);
    phase = PH_RECV;
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_rsps.size() == 0);
    repeat (Latency + 4) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Request driver; inputs change on the falling edge.
  logic drained;
  assign drained = (expected_rsps.size() == 0);

  // Whether the request on the bus was taken at the last rising edge.
  logic in_taken;
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
  end

  int paused_once;
  initial paused_once = 0;

  always @(negedge clk) begin
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (in_valid && !in_taken) begin
      // Hold the request until taken.
    end else begin
      offer = (phase == PH_SEND) ? ($urandom_range(0, 99) >= 74) :
              (phase == PH_BOTH) ? ($urandom_range(0, 99) >= 12) : 1'b1;
      // Once, the sender pauses until every response has come back.
      if (paused_once == 0 && pending_reqs.size() == 700) begin
        if (drained) paused_once = 1;
        offer = 1'b0;
      end
      if (offer && pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    errors    = 0;
  end

  // Receiver ready pattern.
  always @(negedge clk) begin
    if (hold_recv) begin
      out_ready <= 1'b0;
    end else if (phase == PH_RECV) begin
      out_ready <= ($urandom_range(0, 99) >= 74);
    end else if (phase == PH_BOTH) begin
      out_ready <= ($urandom_range(0, 99) >= 12);
    end else begin
      out_ready <= rst_n;
    end
  end

  // Monitor: predict on request acceptance, check on response acceptance.
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(nearest_point_distance(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response %h", $time, out_data);
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (out_data.distance_squared !== want.distance_squared) begin
            $display("%0t: distance_squared expected %0d got %0d", $time,
                     want.distance_squared, out_data.distance_squared);
            errors++;
          end
          if (out_data.segment_fraction !== want.segment_fraction) begin
            $display("%0t: segment_fraction expected %0d got %0d", $time,
                     want.segment_fraction, out_data.segment_fraction);
            errors++;
          end
          if (out_data.nearest_x !== want.nearest_x) begin
            $display("%0t: nearest_x expected %0d got %0d", $time,
                     want.nearest_x, out_data.nearest_x);
            errors++;
          end
          if (out_data.nearest_y !== want.nearest_y) begin
            $display("%0t: nearest_y expected %0d got %0d", $time,
                     want.nearest_y, out_data.nearest_y);
            errors++;
          end
          if (out_data.nearest_z !== want.nearest_z) begin
            $display("%0t: nearest_z expected %0d got %0d", $time,
                     want.nearest_z, out_data.nearest_z);
            errors++;
          end
          if (out_data.degenerate !== want.degenerate) begin
            $display("%0t: degenerate expected %0b got %0b", $time,
                     want.degenerate, out_data.degenerate);
            errors++;
          end
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= (rst_n === 1'b0 && cycle_count === 'x) ? 0 : cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule

/* point_segment_distance_squared_core.f */
sv/psd_pkg.sv
sv/psd_div.sv
sv/point_segment_distance_squared_core.sv
sv/psd_checker.sv
tb/tb_point_segment_distance_squared_core.sv
